// File: rtl/core/apfr_pkg.sv
// ----------------------------------------------------------------------------
// apfr_pkg
// Shared types, protocol constants and the checksum step of the alarm panel
// frame receiver.
// ----------------------------------------------------------------------------
package apfr_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'hFE;
    localparam logic [7:0]  ESC_FE      = 8'hF0;
    localparam logic [7:0]  END_BYTE    = 8'h0D;
    localparam logic [15:0] SUM_SEED    = 16'h147A;
    localparam logic [7:0]  TYPE_RETURN = 8'hEF;
    localparam logic [7:0]  TYPE_ALARM  = 8'h02;
    localparam logic [7:0]  TYPE_MOVE   = 8'h00;
    localparam int          HDR_DEPTH   = 5;

    typedef enum logic [1:0] {
        KIND_ALARM   = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RETURN  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_FRAME
    } frame_state_t;

    typedef struct packed {
        logic        ok;
        kind_t       kind;
        logic [31:0] mask;
        logic [31:0] changed;
    } frame_result_t;

    // rotate left, invert, fold high byte and add the data byte
    function automatic logic [15:0] sum_step(input logic [15:0] r, input logic [7:0] b);
        logic [15:0] v;
        v = ~{r[14:0], r[15]};
        return v + {8'h00, v[15:8]} + {8'h00, b};
    endfunction

endpackage

// File: rtl/core/alarm_panel_frame_receiver.sv
// ----------------------------------------------------------------------------
// alarm_panel_frame_receiver
// Deframes the panel byte stream, checks the rotate-invert-add checksum and
// reports alarm, movement, return and unknown-type frames.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_stall is low. Each byte is held
// in the input register and is folded into the frame state when it advances, and
// a completed frame is written to the output register as its end byte is folded.
// Only a frame end byte can wait: it is held while a previous result is still
// stalled on the output, and so is the byte behind it. Frames longer than
// MAX_FRAME stored bytes are dropped.
module alarm_panel_frame_receiver
    import apfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  type_code,
    output logic [31:0] zone_mask,
    output logic [31:0] changed_mask,
    output logic [7:0]  reply_code
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    frame_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               prev_fe_reg, prev_fe_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         held0_reg, held0_next;
    logic [7:0]         held1_reg, held1_next;
    logic [7:0]         hdr_reg [HDR_DEPTH];
    logic [31:0]        alarm_reg;

    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [7:0]         type_reg;
    logic [31:0]        mask_reg;
    logic [31:0]        changed_reg;
    logic [7:0]         ret_reg;

    logic               do_store;
    logic               store_ok;
    logic [7:0]         store_byte;
    logic               end_frame;
    logic               emit;
    logic               out_free;
    logic               advance;
    frame_result_t      res;

    apfr_finish #(
        .CNT_W (CNT_W)
    ) u_finish (
        .frame_len   (cnt_reg),
        .hdr         (hdr_reg),
        .held0       (held0_reg),
        .held1       (held1_reg),
        .sum         (sum_reg),
        .alarm_zones (alarm_reg),
        .res         (res)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        prev_fe_next = prev_fe_reg;
        sum_next     = sum_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        do_store     = 1'b0;
        store_byte   = byte_reg;
        end_frame    = 1'b0;
        unique case (state_reg)
            ST_HUNT0:
            begin
                prev_fe_next = 1'b0;
                if (byte_reg == SYNC_BYTE)
                begin
                    state_next = ST_HUNT1;
                end
            end
            ST_HUNT1:
            begin
                prev_fe_next = 1'b0;
                if (byte_reg == SYNC_BYTE)
                begin
                    state_next = ST_FRAME;
                    cnt_next   = '0;
                    sum_next   = SUM_SEED;
                end
                else
                begin
                    state_next = ST_HUNT0;
                end
            end
            ST_FRAME:
            begin
                if (prev_fe_reg)
                begin
                    if (byte_reg == END_BYTE)
                    begin
                        end_frame    = 1'b1;
                        state_next   = ST_HUNT0;
                        prev_fe_next = 1'b0;
                    end
                    else if (byte_reg == ESC_FE)
                    begin
                        do_store   = 1'b1;
                        store_byte = SYNC_BYTE;
                    end
                    else if (byte_reg == SYNC_BYTE)
                    begin
                        cnt_next     = '0;
                        sum_next     = SUM_SEED;
                        prev_fe_next = 1'b0;
                    end
                    else
                    begin
                        state_next   = ST_HUNT0;
                        prev_fe_next = 1'b0;
                    end
                end
                else if (byte_reg != SYNC_BYTE)
                begin
                    do_store = 1'b1;
                end
                else
                begin
                    prev_fe_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_HUNT0;
            end
        endcase

        store_ok = do_store && (cnt_reg < CNT_W'(MAX_FRAME));
        if (do_store)
        begin
            prev_fe_next = 1'b0;
            if (!store_ok)
            begin
                // overflow drops the frame
                state_next = ST_HUNT0;
            end
            else
            begin
                if (cnt_reg >= CNT_W'(2))
                begin
                    sum_next = sum_step(sum_reg, held0_reg);
                end
                held0_next = held1_reg;
                held1_next = store_byte;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = in_valid_reg && end_frame && res.ok;
    assign advance   = in_valid_reg && (out_free || !(end_frame && res.ok));
    assign in_stall  = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FRAME;
            cnt_reg     <= '0;
            prev_fe_reg <= 1'b0;
            sum_reg     <= SUM_SEED;
            alarm_reg   <= 32'h0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            prev_fe_reg <= prev_fe_next;
            sum_reg     <= sum_next;
            if (emit && res.kind == KIND_ALARM)
            begin
                alarm_reg <= res.mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            for (int i = 0; i < HDR_DEPTH; i++)
            begin
                if (store_ok && cnt_reg == CNT_W'(i))
                begin
                    hdr_reg[i] <= store_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg    <= res.kind;
            type_reg    <= hdr_reg[0];
            mask_reg    <= res.mask;
            changed_reg <= res.changed;
            ret_reg     <= hdr_reg[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign type_code    = type_reg;
    assign zone_mask    = mask_reg;
    assign changed_mask = changed_reg;
    assign reply_code   = ret_reg;

endmodule

// File: rtl/core/apfr_finish.sv
// ----------------------------------------------------------------------------
// apfr_finish
// Frame end evaluation: length and checksum check, zone mask assembly and
// message classification.
// ----------------------------------------------------------------------------
module apfr_finish
    import apfr_pkg::*;
#(
    parameter int CNT_W = 7
)
(
    input  logic [CNT_W-1:0] frame_len,
    input  logic [7:0]       hdr [HDR_DEPTH],
    input  logic [7:0]       held0,
    input  logic [7:0]       held1,
    input  logic [15:0]      sum,
    input  logic [31:0]      alarm_zones,
    output frame_result_t    res
);

    logic [31:0] mask_raw;

    always_comb
    begin
        if (frame_len >= CNT_W'(7))
        begin
            mask_raw = {hdr[4], hdr[3], hdr[2], hdr[1]};
        end
        else if (frame_len >= CNT_W'(5))
        begin
            mask_raw = {16'h0000, hdr[2], hdr[1]};
        end
        else if (frame_len >= CNT_W'(4))
        begin
            mask_raw = {24'h000000, hdr[1]};
        end
        else
        begin
            mask_raw = 32'h0;
        end
    end

    always_comb
    begin
        res.ok      = (frame_len >= CNT_W'(3)) && (held0 == sum[15:8])
                      && (held1 == sum[7:0]);
        res.changed = 32'h0;
        res.mask    = 32'h0;
        case (hdr[0])
            TYPE_ALARM:
            begin
                res.kind    = KIND_ALARM;
                res.mask    = mask_raw;
                res.changed = alarm_zones ^ mask_raw;
            end
            TYPE_MOVE:
            begin
                res.kind = KIND_MOVE;
                res.mask = mask_raw;
            end
            TYPE_RETURN:
            begin
                res.kind = KIND_RETURN;
            end
            default:
            begin
                res.kind = KIND_UNKNOWN;
            end
        endcase
    end

endmodule

// File: rtl/core/apfr_checker.sv
// ----------------------------------------------------------------------------
// apfr_checker
// Port-level checks of the alarm panel frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module apfr_checker
    import apfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  type_code,
    input logic [31:0] zone_mask,
    input logic [31:0] changed_mask,
    input logic [7:0]  reply_code
);

    // a changed mask only comes with alarm frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed_mask != 32'h0 |-> kind == KIND_ALARM)
        else $error("changed mask on a non-alarm item");

    // return and unknown frames carry no zones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_RETURN || kind == KIND_UNKNOWN) |-> zone_mask == 32'h0)
        else $error("zone mask on a return or unknown item");

    // kind follows the type code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_ALARM) == (type_code == TYPE_ALARM)
                   && (kind == KIND_MOVE) == (type_code == TYPE_MOVE)
                   && (kind == KIND_RETURN) == (type_code == TYPE_RETURN))
        else $error("kind does not match type code");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(zone_mask)
                                  && $stable(changed_mask) && $stable(type_code)
                                  && $stable(reply_code))
        else $error("stalled result changed");

    // a stalled input item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
        else $error("stalled input item changed");

endmodule

bind alarm_panel_frame_receiver apfr_checker u_apfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .type_code    (type_code),
    .zone_mask    (zone_mask),
    .changed_mask (changed_mask),
    .reply_code   (reply_code)
);

// File: tb/alarm_panel_frame_receiver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_panel_frame_receiver_checker
// Watches both channels of the frame receiver and tracks sync hunting,
// unescaping, the running checksum and the zone state for every accepted
// byte. Each decoded frame that passes the length and checksum check is queued
// and compared field by field with the next result that leaves the block.
// ----------------------------------------------------------------------------
module alarm_panel_frame_receiver_checker
    import apfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  type_code,
    input  logic [31:0] zone_mask,
    input  logic [31:0] changed_mask,
    input  logic [7:0]  reply_code,
    output int          mismatch_count,
    output int          reports_due
);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  type_code;
        logic [31:0] zone;
        logic [31:0] changed;
        logic [7:0]  answer;
    } frame_report_t;

    int            frame_pos = 0;
    logic [7:0]    last_byte = 8'h00;
    logic [15:0]   link_sum = SUM_SEED;
    logic [7:0]    tail_bytes [2];
    logic [7:0]    head_bytes [HDR_DEPTH];
    logic [31:0]   alarm_now = 32'h0;
    int            mismatches = 0;
    frame_report_t pending_reports [$];
    frame_report_t want;

    function automatic logic [15:0] fold_byte(input logic [15:0] r, input logic [7:0] b);
        logic [15:0] rot;
        rot = {r[14:0], r[15]} ^ 16'hFFFF;
        return rot + {8'h00, rot[15:8]} + {8'h00, b};
    endfunction

    task automatic keep_byte(input logic [7:0] b);
        if (frame_pos >= MAX_FRAME)
        begin
            frame_pos = -2;
            last_byte = 8'h00;
            return;
        end
        if (frame_pos < HDR_DEPTH)
            head_bytes[frame_pos] = b;
        if (frame_pos >= 2)
            link_sum = fold_byte(link_sum, tail_bytes[0]);
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        frame_pos++;
    endtask

    task automatic close_frame(input int len);
        frame_report_t rep;
        int            pay;
        logic [31:0]   mask;
        pay = len - 3;
        mask = 32'h0;
        if (len < 3 || {tail_bytes[0], tail_bytes[1]} != link_sum)
            return;
        if (pay >= 4)
            mask = {head_bytes[4], head_bytes[3], head_bytes[2], head_bytes[1]};
        else if (pay >= 2)
            mask = {16'h0, head_bytes[2], head_bytes[1]};
        else if (pay >= 1)
            mask = {24'h0, head_bytes[1]};
        rep.changed = 32'h0;
        case (head_bytes[0])
            TYPE_ALARM:
            begin
                rep.kind = KIND_ALARM;
                rep.changed = alarm_now ^ mask;
                alarm_now = mask;
            end
            TYPE_MOVE:
                rep.kind = KIND_MOVE;
            TYPE_RETURN:
            begin
                rep.kind = KIND_RETURN;
                mask = 32'h0;
            end
            default:
            begin
                rep.kind = KIND_UNKNOWN;
                mask = 32'h0;
            end
        endcase
        rep.type_code = head_bytes[0];
        rep.zone = mask;
        rep.answer = head_bytes[1];
        pending_reports.insert(pending_reports.size(), rep);
    endtask

    task automatic take_byte(input logic [7:0] b);
        int len;
        if (frame_pos < 0)
        begin
            if (b == SYNC_BYTE)
            begin
                frame_pos++;
                last_byte = 8'h00;
                if (frame_pos == 0)
                    link_sum = SUM_SEED;
            end
            else
                frame_pos = -2;
        end
        else if (last_byte == SYNC_BYTE)
        begin
            if (b == END_BYTE)
            begin
                len = frame_pos;
                frame_pos = -2;
                last_byte = 8'h00;
                close_frame(len);
            end
            else if (b == ESC_FE)
            begin
                keep_byte(SYNC_BYTE);
                if (frame_pos >= 0)
                    last_byte = b;
            end
            else if (b == SYNC_BYTE)
            begin
                frame_pos = 0;
                link_sum = SUM_SEED;
                last_byte = 8'h00;
            end
            else
            begin
                frame_pos = -2;
                last_byte = 8'h00;
            end
        end
        else if (b != SYNC_BYTE)
        begin
            keep_byte(b);
            if (frame_pos >= 0)
                last_byte = b;
        end
        else
            last_byte = b;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos = 0;
            last_byte = 8'h00;
            link_sum = SUM_SEED;
            alarm_now = 32'h0;
            mismatches = 0;
            pending_reports.delete();
            mismatch_count <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected frame result: kind %0d type %02h",
                                  " zone %08h changed %08h code %02h"},
                                 kind, type_code, zone_mask, changed_mask, reply_code);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (kind !== want.kind || type_code !== want.type_code ||
                        zone_mask !== want.zone || changed_mask !== want.changed ||
                        reply_code !== want.answer)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("frame result mismatch at %0t", $realtime);
                            $display({"  expected kind %0d type %02h zone %08h",
                                      " changed %08h code %02h"},
                                     want.kind, want.type_code, want.zone, want.changed,
                                     want.answer);
                            $display({"  actual   kind %0d type %02h zone %08h",
                                      " changed %08h code %02h"},
                                     kind, type_code, zone_mask, changed_mask, reply_code);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                take_byte(rx_byte);
            mismatch_count <= mismatches;
            reports_due <= pending_reports.size();
        end
    end

endmodule

// File: tb/alarm_panel_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_panel_frame_receiver_test
// Drives the frame receiver with directed frames (every type, payload sizes,
// escapes, restarts, broken escapes, short, corrupt and oversized frames),
// a long output hold-off, then random frame traffic under several idle and
// stall mixes. A checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module alarm_panel_frame_receiver_test
    import apfr_pkg::*;
();

    localparam int MAX_FRAME    = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  type_code;
    logic [31:0] zone_mask;
    logic [31:0] changed_mask;
    logic [7:0]  reply_code;
    int          mismatch_count;
    int          reports_due;

    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          sent_bytes = 0;
    logic [7:0]  body_q [$];

    alarm_panel_frame_receiver #(.MAX_FRAME(MAX_FRAME)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .type_code    (type_code),
        .zone_mask    (zone_mask),
        .changed_mask (changed_mask),
        .reply_code   (reply_code)
    );

    alarm_panel_frame_receiver_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .type_code      (type_code),
        .zone_mask      (zone_mask),
        .changed_mask   (changed_mask),
        .reply_code     (reply_code),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0, 1:    return SYNC_BYTE;
            2:       return ESC_FE;
            3:       return END_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == SYNC_BYTE) ? 8'h5A : b;
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(4))
            0, 1:    return TYPE_ALARM;
            2:       return TYPE_MOVE;
            3:       return TYPE_RETURN;
            default: return pick_byte();
        endcase
    endfunction

    function automatic logic [15:0] body_sum();
        logic [15:0] s;
        logic [15:0] t;
        s = SUM_SEED;
        foreach (body_q[i])
        begin
            t = ~((s << 1) | (s >> 15));
            s = t + {8'h00, t[15:8]} + {8'h00, body_q[i]};
        end
        return s;
    endfunction

    task automatic set_phase(input int p);
        case (p % 4)
            0:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct = 45;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct = 0;
                stall_pct = 45;
            end
            default:
            begin
                idle_pct = 14;
                stall_pct = 14;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input int pay_len, input bit good,
                              input bit synced);
        logic [15:0] sum;
        body_q.delete();
        body_q.insert(body_q.size(), ftype);
        repeat (pay_len) body_q.insert(body_q.size(), pick_byte());
        sum = body_sum();
        if (!good)
            sum ^= 16'h1 << $urandom_range(15);
        body_q.insert(body_q.size(), sum[15:8]);
        body_q.insert(body_q.size(), sum[7:0]);
        if (synced)
        begin
            send_byte(SYNC_BYTE);
            send_byte(SYNC_BYTE);
        end
        foreach (body_q[i])
        begin
            if (body_q[i] == SYNC_BYTE)
            begin
                send_byte(SYNC_BYTE);
                send_byte(ESC_FE);
            end
            else
                send_byte(body_q[i]);
        end
        send_byte(SYNC_BYTE);
        send_byte(END_BYTE);
    endtask

    task automatic send_short(input int len);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        repeat (len) send_byte(plain_byte());
        send_byte(SYNC_BYTE);
        send_byte(END_BYTE);
    endtask

    // frame cut off by a sync pair, then a complete frame
    task automatic send_restart(input int len);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        repeat (len) send_byte(plain_byte());
        send_frame(pick_type(), $urandom_range(0, 6), 1'b1, 1'b1);
    endtask

    task automatic send_broken(input int len);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == SYNC_BYTE || b == ESC_FE || b == END_BYTE)
            b = 8'h77;
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        repeat (len) send_byte(plain_byte());
        send_byte(SYNC_BYTE);
        send_byte(b);
    endtask

    // output side, with one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[alarm_panel_frame_receiver] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int base;
        set_phase(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frame collected without sync straight after reset
        send_frame(TYPE_ALARM, 4, 1'b1, 1'b0);
        send_byte(8'h55);
        send_byte(SYNC_BYTE);
        send_byte(8'h12);
        for (int p = 0; p <= 5; p++)
            send_frame(TYPE_ALARM, p, 1'b1, 1'b1);
        send_frame(TYPE_MOVE, 4, 1'b1, 1'b1);
        send_frame(TYPE_RETURN, 1, 1'b1, 1'b1);
        send_frame(8'hFF, 2, 1'b1, 1'b1);
        send_frame(SYNC_BYTE, 3, 1'b1, 1'b1);
        send_frame(TYPE_ALARM, 4, 1'b0, 1'b1);
        send_short(0);
        send_short(1);
        send_short(2);
        send_restart(2);
        send_broken(2);
        send_frame(TYPE_ALARM, MAX_FRAME - 3, 1'b1, 1'b1);
        send_frame(TYPE_ALARM, MAX_FRAME - 2, 1'b1, 1'b1);
        send_frame(TYPE_ALARM, 0, 1'b1, 1'b1);

        // long output hold-off while frames keep coming
        hold_req = 1'b1;
        repeat (8) send_frame(pick_type(), $urandom_range(0, 3), 1'b1, 1'b1);

        base = sent_bytes;
        while (sent_bytes < 550)
        begin
            set_phase((sent_bytes - base) / 25);
            r = $urandom_range(99);
            if (r < 70)
                send_frame(pick_type(),
                           ($urandom_range(19) == 0) ? $urandom_range(9, MAX_FRAME - 3)
                                                     : $urandom_range(0, 8),
                           1'b1, 1'b1);
            else if (r < 78)
                send_frame(pick_type(), $urandom_range(0, 8), 1'b0, 1'b1);
            else if (r < 83)
                send_short($urandom_range(0, 2));
            else if (r < 88)
                send_restart($urandom_range(0, 4));
            else if (r < 93)
                send_broken($urandom_range(0, 4));
            else if (r < 96)
                send_frame(pick_type(), $urandom_range(MAX_FRAME - 2, MAX_FRAME + 6),
                           1'b1, 1'b1);
            else
                repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && reports_due == 0)
            $display("[alarm_panel_frame_receiver] OK");
        else
            $display("[alarm_panel_frame_receiver] ERROR");
        $finish;
    end

endmodule
